// File: src/rbf_pkg.sv
// Shared types, codes and width constants for the byte ring FIFO.
// No dependencies; every other file in src imports this package.
`default_nettype none

package rbf_pkg;

  // Fixed field widths of the request and result transactions
  localparam int LEN_W   = 13;
  localparam int FILL_W  = 13;
  localparam int BYTE_W  = 8;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int BURST_W = 7;   // holds a burst count of up to 64
  localparam int ADDR_W  = 20;  // widest store address, for DEPTH of 1 M bytes

  localparam int DEF_DEPTH     = 4096;
  localparam int DEF_MAX_BURST = 64;
  localparam int QDEPTH        = 4;  // command queue between front and back

  // Request codes
  localparam logic [REQ_W-1:0] REQ_WRITE_BEGIN = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_BYTE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ        = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK        = 3'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR       = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BUSY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BURST = 2'd3;

  // Back-end operation codes
  localparam logic [1:0] OP_RESP = 2'd0;  // status only
  localparam logic [1:0] OP_WR   = 2'd1;  // store one byte
  localparam logic [1:0] OP_RD   = 2'd2;  // emit a burst of stored bytes

  typedef struct packed {
    logic [1:0]         op;
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  addr;
    logic [BYTE_W-1:0]  data;
    logic [BURST_W-1:0] count;
    logic [FILL_W-1:0]  fill;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/rbf_req_if.sv
// Request channel: valid/ready handshake with request payload.
// Depends on rbf_pkg.
`default_nettype none

interface rbf_req_if;
  import rbf_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [LEN_W-1:0]  length;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output req_type, output length, output data_byte,
                  input ready);
  modport sink   (input valid, input req_type, input length, input data_byte,
                  output ready);
endinterface

`default_nettype wire

// File: src/rbf_rsp_if.sv
// Result channel: valid/ready handshake with result payload.
// Depends on rbf_pkg.
`default_nettype none

interface rbf_rsp_if;
  import rbf_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] out_byte;
  logic              has_byte;
  logic              last;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, output status, output out_byte, output has_byte,
                  output last, output fill_level, input ready);
  modport sink   (input valid, input status, input out_byte, input has_byte,
                  input last, input fill_level, output ready);
endinterface

`default_nettype wire

// File: src/rbf_front.sv
// Front end: accepts requests, checks them against the pointers and counts,
// and turns each into one back-end command. Depends on rbf_pkg, rbf_req_if.
`default_nettype none

module rbf_front #(
  parameter int DEPTH     = rbf_pkg::DEF_DEPTH,
  parameter int MAX_BURST = rbf_pkg::DEF_MAX_BURST
) (
  input  wire logic         clk,
  input  wire logic         rst,
  rbf_req_if.sink           req,
  input  wire logic         q_full,
  output logic              push,
  output rbf_pkg::cmd_t     cmd
);
  import rbf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ((CW > LEN_W) ? CW : LEN_W) + 1;

  logic [PW-1:0] head, head_next, tail, tail_next;
  logic [CW-1:0] fill, fill_next, wr_rem, wr_rem_next;

  logic [EW-1:0] len_e, fill_e, free_e;
  logic [CW-1:0] len_c;
  logic [PW:0]   head_sum;
  logic [PW-1:0] head_adv, tail_inc;
  logic          busy, drained;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  assign len_e  = EW'(req.length);
  assign fill_e = EW'(fill);
  assign free_e = EW'(DEPTH) - fill_e;
  assign len_c  = CW'(req.length);  // used only once length has passed a fill or free-space check
  assign busy   = (wr_rem != '0);

  assign head_sum = (PW+1)'(head) + (PW+1)'(len_c);
  assign head_adv = (head_sum >= (PW+1)'(DEPTH)) ? PW'(head_sum - (PW+1)'(DEPTH))
                                                 : PW'(head_sum);
  assign tail_inc = (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    fill_next   = fill;
    wr_rem_next = wr_rem;
    drained     = 1'b0;
    cmd         = '0;
    cmd.op      = OP_RESP;
    cmd.status  = ST_OK;
    cmd.count   = BURST_W'(1);
    case (req.req_type)
      REQ_CLEAR: begin
        head_next   = '0;
        tail_next   = '0;
        fill_next   = '0;
        wr_rem_next = '0;
      end
      REQ_WRITE_BYTE: begin
        if (!busy) begin
          cmd.status = ST_BUSY;
        end else begin
          cmd.op      = OP_WR;
          cmd.addr    = ADDR_W'(tail);
          cmd.data    = req.data_byte;
          tail_next   = tail_inc;
          fill_next   = fill + 1'b1;
          wr_rem_next = wr_rem - 1'b1;
        end
      end
      REQ_WRITE_BEGIN: begin
        if (busy) begin
          cmd.status = ST_BUSY;
        end else if (len_e > free_e) begin
          cmd.status = ST_SHORT;
        end else begin
          wr_rem_next = len_c;
        end
      end
      REQ_REMOVE: begin
        if (busy) begin
          cmd.status = ST_BUSY;
        end else if (len_e > fill_e) begin
          cmd.status = ST_SHORT;
        end else begin
          head_next = head_adv;
          fill_next = fill - len_c;
          drained   = (fill_next == '0);
        end
      end
      REQ_READ, REQ_PEEK: begin
        if (busy) begin
          cmd.status = ST_BUSY;
        end else if (len_e > EW'(MAX_BURST)) begin
          cmd.status = ST_BURST;
        end else if (len_e > fill_e) begin
          cmd.status = ST_SHORT;
        end else if (len_e != '0) begin
          cmd.op    = OP_RD;
          cmd.addr  = ADDR_W'(head);
          cmd.count = BURST_W'(req.length);
          if (req.req_type == REQ_READ) begin
            head_next = head_adv;
            fill_next = fill - len_c;
            drained   = (fill_next == '0);
          end
        end
      end
      default: begin
        cmd.status = ST_BUSY;
      end
    endcase
    // pointers fold back to zero once the buffer drains
    if (drained) begin
      head_next = '0;
      tail_next = '0;
    end
    cmd.fill = FILL_W'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
      wr_rem <= '0;
    end else if (push) begin
      head   <= head_next;
      tail   <= tail_next;
      fill   <= fill_next;
      wr_rem <= wr_rem_next;
    end
  end

endmodule

`default_nettype wire

// File: src/rbf_queue.sv
// Short command queue between front and back end.
// Depends on rbf_pkg.
`default_nettype none

module rbf_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  rbf_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output rbf_pkg::cmd_t      head_cmd
);
  import rbf_pkg::*;

  localparam int IW = $clog2(QDEPTH);

  cmd_t          entries [QDEPTH];
  logic [IW-1:0] wr_idx, rd_idx;
  logic [IW:0]   count;

  assign full       = (count == (IW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/rbf_back.sv
// Back end: byte store, burst sequencer, read-data stage and output register.
// Depends on rbf_pkg, rbf_rsp_if.
`default_nettype none

module rbf_back #(
  parameter int DEPTH = rbf_pkg::DEF_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  rbf_pkg::cmd_t      q_cmd,
  output logic               pop,
  rbf_rsp_if.source          rsp
);
  import rbf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [BYTE_W-1:0]  store [DEPTH];
  logic [BYTE_W-1:0]  rd_data;

  logic [BURST_W-1:0] idx;
  logic [PW:0]        addr_sum;
  logic [PW-1:0]      mem_addr;
  logic               out_free, s1_free, issue, is_last;

  // stage 1: result waiting for its store read
  logic              s1_valid;
  logic [STAT_W-1:0] s1_status;
  logic              s1_has, s1_last;
  logic [FILL_W-1:0] s1_fill;

  assign out_free = !rsp.valid || rsp.ready;
  assign s1_free  = !s1_valid || out_free;
  assign issue    = q_valid && s1_free;
  assign is_last  = (q_cmd.op != OP_RD) || (idx == q_cmd.count - 1'b1);
  assign pop      = issue && is_last;

  assign addr_sum = (PW+1)'(q_cmd.addr[PW-1:0]) + (PW+1)'(idx);
  assign mem_addr = (addr_sum >= (PW+1)'(DEPTH)) ? PW'(addr_sum - (PW+1)'(DEPTH))
                                                 : PW'(addr_sum);

  always_ff @(posedge clk) begin
    if (issue && q_cmd.op == OP_WR) begin
      store[mem_addr] <= q_cmd.data;
    end
    if (issue && q_cmd.op == OP_RD) begin
      rd_data <= store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (issue) begin
      idx <= is_last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && s1_free) begin
      s1_status <= q_cmd.status;
      s1_has    <= (q_cmd.op == OP_RD);
      s1_last   <= is_last;
      s1_fill   <= q_cmd.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_free) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      rsp.status     <= s1_status;
      rsp.out_byte   <= s1_has ? rd_data : '0;
      rsp.has_byte   <= s1_has;
      rsp.last       <= s1_last;
      rsp.fill_level <= s1_fill;
    end
  end

endmodule

`default_nettype wire

// File: src/byte_ring_fifo_atomic_rw.sv
// Top level of the byte ring FIFO with all-or-nothing multi-byte requests.
// Depends on rbf_pkg, rbf_req_if, rbf_rsp_if, rbf_front, rbf_queue, rbf_back.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type[2:0], length[12:0], data_byte[7:0]
//   rsp      out  valid/ready   status[1:0], out_byte[7:0], has_byte, last,
//                               fill_level[12:0]
//
// The front end takes one request per cycle while the command queue is not full;
// the back end replays a read or peek of L bytes as L store reads, one per cycle
// while the output is not stalled, and every other request as one command. Write
// bytes and read bytes therefore stream at one per cycle unless rsp stalls.
// A result passes the command queue, stage 1 and the output register in turn.
// Reset (rst, synchronous) empties the buffer and closes any open write; the
// store itself is not cleared, as only written bytes are ever read.
// A stall on rsp backs up through the output register and stage 1 into the
// four-entry command queue; req.ready falls only when that queue is full.
`default_nettype none

module byte_ring_fifo_atomic_rw #(
  parameter int DEPTH     = rbf_pkg::DEF_DEPTH,
  parameter int MAX_BURST = rbf_pkg::DEF_MAX_BURST
) (
  input  wire logic clk,
  input  wire logic rst,
  rbf_req_if.sink   req,
  rbf_rsp_if.source rsp
);
  import rbf_pkg::*;

  // front end -> queue
  logic push, q_full;
  cmd_t push_cmd;

  // queue -> back end
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // Front end owns the pointers, fill count and open-write count, so every
  // request is judged against the state left by all earlier ones.
  rbf_front #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  rbf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // Back end holds the store and replays commands strictly in order, so a
  // byte written is always in the store before a later read reaches it.
  rbf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (q_pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// File: src/rbf_checker.sv
// Port-level checks on the result channel, bound to the top level.
// Depends on rbf_pkg and byte_ring_fifo_atomic_rw.
`default_nettype none

module rbf_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic [rbf_pkg::STAT_W-1:0] rsp_status,
  input wire logic [rbf_pkg::BYTE_W-1:0] rsp_out_byte,
  input wire logic                      rsp_has_byte,
  input wire logic                      rsp_last
);
  import rbf_pkg::*;

  // a stalled transaction keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                && $stable(rsp_status) && $stable(rsp_last))
    else $error("result changed while stalled");

  // data only ever comes with an ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_has_byte |-> rsp_status == ST_OK)
    else $error("data byte with non-ok status");

  // results without data carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_has_byte |-> rsp_out_byte == '0)
    else $error("non-zero byte without data");

  // refusals are single results
  a_refuse_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_last)
    else $error("refusal not marked last");

endmodule

bind byte_ring_fifo_atomic_rw rbf_checker u_rbf_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_out_byte (rsp.out_byte),
  .rsp_has_byte (rsp.has_byte),
  .rsp_last     (rsp.last)
);

`default_nettype wire

// File: test/byte_ring_fifo_atomic_rw_test.sv
// Self-checking testbench for the byte ring FIFO with all-or-nothing requests.
// Depends on rbf_pkg, rbf_req_if, rbf_rsp_if and the byte_ring_fifo_atomic_rw RTL.
// A cycle-free model of the ring predicts every result transaction in order.
`default_nettype none

module byte_ring_fifo_atomic_rw_test;
  import rbf_pkg::*;

  localparam int RING_DEPTH  = DEF_DEPTH;
  localparam int BURST_MAX   = DEF_MAX_BURST;
  localparam int LEN_MAX     = (1 << LEN_W) - 1;
  localparam int CYCLE_LIMIT = 2_000_000;

  // Request codes the block does not know; it must answer them as busy
  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              last;
    logic [FILL_W-1:0] fill_level;
  } fifo_result_t;

  logic clk;
  logic rst;

  rbf_req_if req_ch ();
  rbf_rsp_if rsp_ch ();

  byte_ring_fifo_atomic_rw #(
    .DEPTH    (RING_DEPTH),
    .MAX_BURST(BURST_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Period 10: high 5, low 5
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Model of the ring. Updated at the rising edge of every request transaction,
  // so the stimulus tasks may look at it once a send has returned.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int rd_ptr;
  int wr_ptr;
  int byte_count;
  int write_left;     // bytes still owed to the open write; zero when none open

  fifo_result_t due_results [$];   // results owed by the block, oldest first

  int  mismatches;
  int  items_sent;
  int  cycle_count;
  bit  idle_on;       // random gaps on both channels
  int  hold_len;      // long receiver hold-off requested by a test

  task automatic push_result(input logic [STAT_W-1:0] st, input logic [BYTE_W-1:0] b,
                             input logic has, input logic fin);
    due_results.push_back('{st, b, has, fin, FILL_W'(byte_count)});
  endtask

  // One request in, the results it causes pushed onto due_results.
  task automatic fifo_step(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] len,
                           input logic [BYTE_W-1:0] dat);
    int n;
    int p;
    int i;
    logic [BYTE_W-1:0] burst [$];
    n = int'(len);
    if (kind == REQ_CLEAR) begin
      // clear always wins, and shuts any open write
      rd_ptr     = 0;
      wr_ptr     = 0;
      byte_count = 0;
      write_left = 0;
      push_result(ST_OK, '0, 1'b0, 1'b1);
    end else if (kind == REQ_WRITE_BYTE) begin
      if (write_left == 0) begin
        push_result(ST_BUSY, '0, 1'b0, 1'b1);  // stray byte, dropped
      end else begin
        ring_mem[wr_ptr] = dat;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        byte_count++;
        write_left--;
        push_result(ST_OK, '0, 1'b0, 1'b1);
      end
    end else if (kind > REQ_CLEAR || write_left != 0) begin
      push_result(ST_BUSY, '0, 1'b0, 1'b1);
    end else if (kind == REQ_WRITE_BEGIN) begin
      if (n > RING_DEPTH - byte_count) begin
        push_result(ST_SHORT, '0, 1'b0, 1'b1);
      end else begin
        write_left = n;
        push_result(ST_OK, '0, 1'b0, 1'b1);
      end
    end else if (kind == REQ_REMOVE) begin
      // no burst limit on remove
      if (n > byte_count) begin
        push_result(ST_SHORT, '0, 1'b0, 1'b1);
      end else begin
        rd_ptr = (rd_ptr + n) % RING_DEPTH;
        byte_count -= n;
        if (byte_count == 0) begin
          rd_ptr = 0;
          wr_ptr = 0;
        end
        push_result(ST_OK, '0, 1'b0, 1'b1);
      end
    end else if (n > BURST_MAX) begin
      // burst check comes before the fill check
      push_result(ST_BURST, '0, 1'b0, 1'b1);
    end else if (n > byte_count) begin
      push_result(ST_SHORT, '0, 1'b0, 1'b1);
    end else if (n == 0) begin
      push_result(ST_OK, '0, 1'b0, 1'b1);
    end else begin
      p = rd_ptr;
      for (i = 0; i < n; i++) begin
        burst.push_back(ring_mem[p]);
        p = (p + 1) % RING_DEPTH;
      end
      if (kind == REQ_READ) begin
        rd_ptr = p;
        byte_count -= n;
        if (byte_count == 0) begin
          rd_ptr = 0;
          wr_ptr = 0;
        end
      end
      // fill level is the post-request value on every byte of the burst
      for (i = 0; i < n; i++)
        push_result(ST_OK, burst[i], 1'b1, i == n - 1);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    fifo_result_t want;
    if (due_results.size() == 0) begin
      $error("result transaction with nothing owed: status %0d", rsp_ch.status);
      mismatches++;
      return;
    end
    want = due_results.pop_front();
    compare_field("status", 16'(want.status), 16'(rsp_ch.status));
    compare_field("out_byte", 16'(want.out_byte), 16'(rsp_ch.out_byte));
    compare_field("has_byte", 16'(want.has_byte), 16'(rsp_ch.has_byte));
    compare_field("last", 16'(want.last), 16'(rsp_ch.last));
    compare_field("fill_level", 16'(want.fill_level), 16'(rsp_ch.fill_level));
  endtask

  // Both channels are sampled at the rising edge; request first, so a result
  // can never be looked at before the request that caused it.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        fifo_step(req_ch.req_type, req_ch.length, req_ch.data_byte);
      if (rsp_ch.valid && rsp_ch.ready)
        check_result();
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus the long hold-off that the
  // back-pressure test asks for. hold_len is written by tests only at a rising
  // edge and taken here only at a falling edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Called at a falling edge, returns at a falling edge with
  // valid still high, so back-to-back transactions never drop valid.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic [REQ_W-1:0] kind, input int len = 0,
                          input int dat = 0);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.length    <= LEN_W'(len);
    req_ch.data_byte <= BYTE_W'(dat);
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Well-formed write: begin, then exactly the promised bytes
  task automatic write_burst(input int n);
    int i;
    send_req(REQ_WRITE_BEGIN, n);
    for (i = 0; i < n; i++)
      send_req(REQ_WRITE_BYTE, 0, $urandom_range(0, 255));
  endtask

  // Quiet the request side and wait for every owed result
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic hold_receiver(input int cycles);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    hold_len = cycles;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Refusals, busy answers, zero lengths and field extremes on a tiny fill
  task automatic test_corner_requests();
    send_req(REQ_WRITE_BYTE, 0, 8'hFF);        // byte with no write open
    send_req(REQ_UNUSED_6, LEN_MAX, 8'hFF);
    send_req(REQ_UNUSED_7);
    send_req(REQ_READ, 0);                     // zero length on empty ring
    send_req(REQ_PEEK, 0);
    send_req(REQ_READ, 1);                     // data short
    send_req(REQ_REMOVE, 1);
    send_req(REQ_PEEK, BURST_MAX + 1);         // burst too long, even when empty
    send_req(REQ_READ, LEN_MAX);
    send_req(REQ_WRITE_BEGIN, LEN_MAX);        // no room
    send_req(REQ_WRITE_BEGIN, 0);              // opens nothing
    send_req(REQ_WRITE_BEGIN, 3);
    send_req(REQ_READ, 1);                     // busy while the write is open
    send_req(REQ_WRITE_BEGIN, 1);
    send_req(REQ_REMOVE, 0);
    send_req(REQ_WRITE_BYTE, 0, 8'h00);
    send_req(REQ_WRITE_BYTE, 0, 8'hFF);
    send_req(REQ_WRITE_BYTE, 0, 8'h5A);
    send_req(REQ_WRITE_BYTE, 0, 8'h11);        // one byte too many
    send_req(REQ_PEEK, 3);
    send_req(REQ_READ, 2);
    send_req(REQ_REMOVE, 1);                   // drains, pointers back to zero
    send_req(REQ_WRITE_BEGIN, 2);
    send_req(REQ_WRITE_BYTE, 0, 8'hA5);
    send_req(REQ_CLEAR);                       // closes the half-done write
    send_req(REQ_WRITE_BYTE, 0, 8'h3C);
  endtask

  // Exact-fit and one-over space checks, a long write shut by clear, and
  // bursts at and just past the limit
  task automatic test_fill_and_burst_limits();
    int i;
    send_req(REQ_CLEAR);
    send_req(REQ_WRITE_BEGIN, RING_DEPTH + 1); // one more than the store holds
    send_req(REQ_WRITE_BEGIN, RING_DEPTH);     // exact fit, write opened
    for (i = 0; i < 3; i++)
      send_req(REQ_WRITE_BYTE, 0, $urandom_range(0, 255));
    send_req(REQ_REMOVE, 1);                   // busy, write still open
    send_req(REQ_CLEAR);                       // shuts the long write
    write_burst(BURST_MAX + 8);
    send_req(REQ_WRITE_BEGIN, RING_DEPTH - BURST_MAX - 7);  // one byte short of room
    send_req(REQ_PEEK, BURST_MAX);
    send_req(REQ_READ, BURST_MAX + 1);         // burst too long
    send_req(REQ_READ, BURST_MAX);
    send_req(REQ_REMOVE, 9);                   // one more than stored
    send_req(REQ_READ, 8);                     // drains
  endtask

  // Stop the receiver long enough for the command queue to fill and hold off requests
  task automatic test_backpressure();
    hold_receiver(300);
    write_burst(40);
    send_req(REQ_PEEK, 40);
    send_req(REQ_READ, 40);
    write_burst(8);
  endtask

  // Mostly well-formed traffic with random content, some noise on top.
  // The last stretch runs with no gaps on either channel.
  task automatic test_random_traffic(input int n_items);
    int first;
    int pick;
    int n;
    int room;
    int cap;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if (items_sent - first >= n_items - 60)
        idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      room = RING_DEPTH - byte_count;
      if (write_left > 0) begin
        // inside a write: mostly its bytes, now and then an interloper
        case (pick)
          0: send_req(REQ_WRITE_BEGIN, $urandom_range(0, 8));
          1: send_req(REQ_READ, $urandom_range(0, 8));
          2: send_req(REQ_PEEK, $urandom_range(0, 8));
          3: send_req(REQ_REMOVE, $urandom_range(0, 8));
          4: send_req(REQ_CLEAR);
          default: send_req(REQ_WRITE_BYTE, 0, $urandom_range(0, 255));
        endcase
      end else if (pick < 35) begin
        cap = (room < 24) ? room : 24;
        n = (pick < 3) ? $urandom_range(room + 1, LEN_MAX) : $urandom_range(0, cap);
        send_req(REQ_WRITE_BEGIN, n);
      end else if (pick < 75) begin
        cap = (byte_count < BURST_MAX) ? byte_count : BURST_MAX;
        if (pick < 38)
          n = $urandom_range(BURST_MAX + 1, LEN_MAX);
        else if (pick < 42)
          n = byte_count + 1;
        else if (pick < 45)
          n = cap;
        else
          n = $urandom_range(0, cap);
        send_req(($urandom_range(0, 2) == 0) ? REQ_PEEK : REQ_READ, n);
      end else if (pick < 86) begin
        n = (pick < 78) ? byte_count + $urandom_range(1, 40) : $urandom_range(0, byte_count);
        send_req(REQ_REMOVE, n);
      end else if (pick < 90) begin
        send_req(REQ_CLEAR);
      end else if (pick < 95) begin
        send_req(REQ_WRITE_BYTE, 0, $urandom_range(0, 255));
      end else begin
        send_req((pick < 98) ? REQ_UNUSED_6 : REQ_UNUSED_7, $urandom_range(0, LEN_MAX),
                 $urandom_range(0, 255));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    mismatches = 0;
    items_sent = 0;
    idle_on    = 1'b1;
    hold_len   = 0;
    rd_ptr     = 0;
    wr_ptr     = 0;
    byte_count = 0;
    write_left = 0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_CLEAR;
    req_ch.length    <= '0;
    req_ch.data_byte <= '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_requests();
    wait_drained();
    test_fill_and_burst_limits();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_traffic(220);
    wait_drained();

    // let any stray late transaction show itself
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
